FILE: rtl/core/abmsl_pkg.sv
// Shared types, constants and the knee curve table for the audio bus mixer
// with soft limiter. Used by every module in rtl/core; depends on nothing.
package abmsl_pkg;

	// Bus and field widths.
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W = 16;
	localparam int PEAK_W = 16;
	localparam int PREMIX_W = 17;
	localparam int COUNT_W = 32;
	localparam int FRAC_W = 15;
	localparam int PROD_W = 33;
	localparam int MIX_W = 34;
	localparam int MAG_W = 33;
	localparam int LIM_W = 30;
	localparam int EXC_W = 29;

	// Configuration port.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MUTE = 2'd0,
		REG_TONE_GAIN = 2'd1,
		REG_DRIVE_GAIN = 2'd2
	} reg_idx_t;

	localparam logic [GAIN_W-1:0] TONE_GAIN_RST = 16'd24576;
	localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = 16'd13107;

	// Limiter constants, all in Q.15 units.
	localparam logic [LIM_W-1:0] FULL_Q15 = 30'd1073709056;
	localparam logic [LIM_W-1:0] KNEE_START = 30'd1020023603;
	localparam int KNEE_T_W = 26;
	localparam logic [KNEE_T_W-1:0] KNEE_WIDTH = 26'd53685453;
	localparam logic [EXC_W-1:0] KNEE_RANGE = 29'd429483624;
	localparam logic [MAG_W-1:0] KNEE_END = MAG_W'(KNEE_START) + MAG_W'(KNEE_RANGE);
	localparam logic [LIM_W-1:0] KNEE_TOP = KNEE_START + LIM_W'(KNEE_WIDTH);

	// Knee table geometry.
	localparam int KNEE_N = 256;
	localparam int KNEE_IDX_W = $clog2(KNEE_N);
	localparam int TAB_IDX_W = KNEE_IDX_W + 1;
	localparam int KNEE_D_W = 22;
	localparam int POS_W = EXC_W + KNEE_IDX_W;

	// Reciprocal for the table index: idx = floor(exc * N / RANGE).
	localparam int IDX_RECIP_W = 10;
	localparam logic [63:0] IDX_RECIP_X =
		(64'd1 << (KNEE_IDX_W + EXC_W)) / 64'(KNEE_RANGE);
	localparam logic [IDX_RECIP_W-1:0] IDX_RECIP = IDX_RECIP_W'(IDX_RECIP_X);
	localparam int IDX_PROD_W = EXC_W + IDX_RECIP_W;

	// Reciprocal for the interpolation quotient: floor(d * rem / RANGE).
	localparam int REM_LO_W = 16;
	localparam int REM_HI_W = EXC_W - REM_LO_W;
	localparam int PLO_W = KNEE_D_W + REM_LO_W;
	localparam int PHI_W = KNEE_D_W + REM_HI_W;
	localparam int PROD2_W = KNEE_D_W + EXC_W;
	localparam int FRAC_DROP = 20;
	localparam int QUO_SHIFT = 32;
	localparam int RECIP2_W = 24;
	localparam logic [63:0] RECIP2_X =
		(64'd1 << (FRAC_DROP + QUO_SHIFT)) / 64'(KNEE_RANGE);
	localparam logic [RECIP2_W-1:0] RECIP2 = RECIP2_W'(RECIP2_X);
	localparam int QM_W = (PROD2_W - FRAC_DROP) + RECIP2_W;

	// Pipeline depth: four stages in the mixer, eleven in the limiter.
	localparam int MIX_STAGES = 4;
	localparam int KNEE_STAGES = 11;
	localparam int PIPE_STAGES = MIX_STAGES + KNEE_STAGES;

	typedef logic [KNEE_T_W-1:0] knee_tab_t [KNEE_N+1];

	// Unsigned long division for the table build; it only runs at elaboration.
	function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Builds knee*(1-exp(-x/knee)) at N+1 equally spaced points over eight
	// knee widths. The ratio between points comes from a Taylor series in Q60.
	function automatic knee_tab_t build_knee_table();
		knee_tab_t tab;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r30;
		logic [63:0] p;
		logic [63:0] kp;
		term = 64'd1 << 60;
		sum = 64'd1 << 60;
		for (int k = 1; k <= 20; k++) begin
			term = div_u64(term * 64'd8, 64'(KNEE_N) * 64'(k));
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r30 = (sum + (64'd1 << 29)) >> 30;
		p = 64'd1 << 30;
		for (int i = 0; i <= KNEE_N; i++) begin
			kp = (64'(KNEE_WIDTH) * p + (64'd1 << 29)) >> 30;
			tab[i] = KNEE_T_W'(64'(KNEE_WIDTH) - kp);
			p = (p * r30 + (64'd1 << 29)) >> 30;
		end
		return tab;
	endfunction

	localparam knee_tab_t KNEE_TABLE = build_knee_table();

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] tone_sample;
		logic signed [SAMPLE_W-1:0] drive_sample;
		logic drive_present;
		logic signed [SAMPLE_W-1:0] cassette_sample;
		logic cassette_present;
		logic clear_meters;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mixed_out;
		logic [PEAK_W-1:0] tone_peak;
		logic [PEAK_W-1:0] drive_peak;
		logic [PEAK_W-1:0] cassette_peak;
		logic [PREMIX_W-1:0] premix_peak;
		logic [PEAK_W-1:0] output_peak;
		logic [COUNT_W-1:0] limited_count;
	} result_t;

	// What the mixer hands to the limiter for one sample.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic neg;
		logic over;
		logic big;
		logic [EXC_W-1:0] exc;
		logic [PEAK_W-1:0] tone_pk;
		logic [PEAK_W-1:0] drive_pk;
		logic [PEAK_W-1:0] cas_pk;
		logic clr;
	} mix_t;

	typedef struct packed {
		mix_t mix;
		logic [LIM_W-1:0] lim;
	} knee_t;

	typedef struct packed {
		logic push;
		logic mute;
	} meter_ctl_t;

endpackage

FILE: rtl/core/abmsl_mix.sv
// Mixer front end: input register, gain multiplies, bus sum and magnitude.
// Depends on abmsl_pkg.
module abmsl_mix import abmsl_pkg::*; (
	input logic clk,
	input logic en,
	input sample_t sample,
	input logic [GAIN_W-1:0] tone_gain,
	input logic [GAIN_W-1:0] drive_gain,
	output mix_t mix
);

	sample_t in_s1;
	logic signed [PROD_W-1:0] tone_p_s2;
	logic signed [PROD_W-1:0] drive_p_s2;
	logic signed [PROD_W-1:0] cas_p_s2;
	logic clr_s2;
	logic signed [MIX_W-1:0] mix_s3;
	logic [PEAK_W-1:0] tone_pk_s3;
	logic [PEAK_W-1:0] drive_pk_s3;
	logic [PEAK_W-1:0] cas_pk_s3;
	logic clr_s3;
	mix_t mix_s4;

	logic signed [PROD_W-1:0] tone_p;
	logic signed [PROD_W-1:0] drive_p;
	logic signed [PROD_W-1:0] cas_p;
	logic [PROD_W-1:0] tone_abs;
	logic [PROD_W-1:0] drive_abs;
	logic [PROD_W-1:0] cas_abs;
	logic signed [MIX_W-1:0] mix_sum;
	logic [MIX_W-1:0] mix_abs;
	mix_t mix_nxt;

	// Products in Q.15; an absent source counts as zero.
	always_comb begin
		tone_p = $signed(in_s1.tone_sample) * $signed({1'b0, tone_gain});
		drive_p = '0;
		if (in_s1.drive_present) begin
			drive_p = $signed(in_s1.drive_sample) * $signed({1'b0, drive_gain});
		end
		cas_p = '0;
		if (in_s1.cassette_present) begin
			cas_p = PROD_W'($signed({in_s1.cassette_sample, 15'd0}));
		end
	end

	always_comb begin
		mix_sum = MIX_W'(tone_p_s2) + MIX_W'(drive_p_s2) + MIX_W'(cas_p_s2);
		tone_abs = tone_p_s2[PROD_W-1] ? PROD_W'(-tone_p_s2) : PROD_W'(tone_p_s2);
		drive_abs = drive_p_s2[PROD_W-1] ? PROD_W'(-drive_p_s2) : PROD_W'(drive_p_s2);
		cas_abs = cas_p_s2[PROD_W-1] ? PROD_W'(-cas_p_s2) : PROD_W'(cas_p_s2);
	end

	always_comb begin
		mix_abs = mix_s3[MIX_W-1] ? MIX_W'(-mix_s3) : MIX_W'(mix_s3);
		mix_nxt.mag = mix_abs[MAG_W-1:0];
		mix_nxt.neg = mix_s3[MIX_W-1];
		mix_nxt.over = mix_nxt.mag > MAG_W'(KNEE_START);
		mix_nxt.big = mix_nxt.mag >= KNEE_END;
		mix_nxt.exc = EXC_W'(mix_nxt.mag - MAG_W'(KNEE_START));
		mix_nxt.tone_pk = tone_pk_s3;
		mix_nxt.drive_pk = drive_pk_s3;
		mix_nxt.cas_pk = cas_pk_s3;
		mix_nxt.clr = clr_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= sample;
			tone_p_s2 <= tone_p;
			drive_p_s2 <= drive_p;
			cas_p_s2 <= cas_p;
			clr_s2 <= in_s1.clear_meters;
			mix_s3 <= mix_sum;
			tone_pk_s3 <= tone_abs[FRAC_W +: PEAK_W];
			drive_pk_s3 <= drive_abs[FRAC_W +: PEAK_W];
			cas_pk_s3 <= cas_abs[FRAC_W +: PEAK_W];
			clr_s3 <= clr_s2;
			mix_s4 <= mix_nxt;
		end
	end

	assign mix = mix_s4;

endmodule

FILE: rtl/core/abmsl_knee.sv
// Soft limiter: table index by reciprocal multiply, table read, linear
// interpolation and the limited magnitude. Depends on abmsl_pkg.
module abmsl_knee import abmsl_pkg::*; (
	input logic clk,
	input logic en,
	input mix_t mix,
	output knee_t knee
);

	mix_t mix_s5;
	mix_t mix_s6;
	mix_t mix_s7;
	mix_t mix_s8;
	mix_t mix_s9;
	mix_t mix_s10;
	mix_t mix_s11;
	mix_t mix_s12;
	mix_t mix_s13;
	mix_t mix_s14;
	mix_t mix_s15;

	logic [KNEE_IDX_W-1:0] qe_s5;
	logic [KNEE_IDX_W-1:0] qe_s6;
	logic [POS_W-1:0] qr_s6;
	logic [KNEE_IDX_W-1:0] idx_s7;
	logic [EXC_W-1:0] rem_s7;
	logic [KNEE_T_W-1:0] a_s8;
	logic [KNEE_D_W-1:0] d_s8;
	logic [EXC_W-1:0] rem_s8;
	logic [KNEE_T_W-1:0] a_s9;
	logic [KNEE_D_W-1:0] d_s9;
	logic [REM_HI_W-1:0] rem_hi_s9;
	logic [PLO_W-1:0] plo_s9;
	logic [KNEE_T_W-1:0] a_s10;
	logic [PLO_W-1:0] plo_s10;
	logic [PHI_W-1:0] phi_s10;
	logic [KNEE_T_W-1:0] a_s11;
	logic [PROD2_W-1:0] p_s11;
	logic [KNEE_T_W-1:0] a_s12;
	logic [PROD2_W-1:0] p_s12;
	logic [QM_W-1:0] qm_s12;
	logic [KNEE_T_W-1:0] a_s13;
	logic [PROD2_W-1:0] p_s13;
	logic [KNEE_D_W-1:0] qe2_s13;
	logic [PROD2_W-1:0] qr2_s13;
	logic [KNEE_T_W-1:0] a_s14;
	logic [KNEE_D_W-1:0] g_s14;
	logic [LIM_W-1:0] lim_s15;

	logic [IDX_PROD_W-1:0] idx_prod;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] rem0;
	logic idx_fix;
	logic [KNEE_IDX_W-1:0] idx_nxt;
	logic [EXC_W-1:0] rem_nxt;
	logic [KNEE_T_W-1:0] tab_a;
	logic [KNEE_T_W-1:0] tab_b;
	logic [KNEE_D_W-1:0] qe2;
	logic [PROD2_W-1:0] r2;
	logic [LIM_W-1:0] knee_sum;
	logic [LIM_W-1:0] lim_pre;
	logic [LIM_W-1:0] lim_nxt;

	// The index estimate is at most one below the true quotient.
	always_comb begin
		idx_prod = IDX_PROD_W'(mix.exc) * IDX_PROD_W'(IDX_RECIP);
		pos = {mix_s6.exc, KNEE_IDX_W'(0)};
		rem0 = pos - qr_s6;
		idx_fix = rem0 >= POS_W'(KNEE_RANGE);
		idx_nxt = idx_fix ? qe_s6 + KNEE_IDX_W'(1) : qe_s6;
		rem_nxt = idx_fix ? EXC_W'(rem0 - POS_W'(KNEE_RANGE)) : EXC_W'(rem0);
	end

	always_comb begin
		tab_a = KNEE_TABLE[{1'b0, idx_s7}];
		tab_b = KNEE_TABLE[{1'b0, idx_s7} + TAB_IDX_W'(1)];
	end

	// Interpolation quotient: estimate from the top bits, then one correction.
	always_comb begin
		qe2 = qm_s12[QUO_SHIFT +: KNEE_D_W];
		r2 = p_s13 - qr2_s13;
	end

	// Excess beyond eight knee widths lands exactly on full scale.
	always_comb begin
		knee_sum = KNEE_START + LIM_W'(a_s14) + LIM_W'(g_s14);
		if (!mix_s14.over) begin
			lim_pre = LIM_W'(mix_s14.mag);
		end else if (mix_s14.big) begin
			lim_pre = KNEE_TOP;
		end else begin
			lim_pre = knee_sum;
		end
		lim_nxt = (lim_pre > FULL_Q15) ? FULL_Q15 : lim_pre;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mix_s5 <= mix;
			mix_s6 <= mix_s5;
			mix_s7 <= mix_s6;
			mix_s8 <= mix_s7;
			mix_s9 <= mix_s8;
			mix_s10 <= mix_s9;
			mix_s11 <= mix_s10;
			mix_s12 <= mix_s11;
			mix_s13 <= mix_s12;
			mix_s14 <= mix_s13;
			mix_s15 <= mix_s14;

			qe_s5 <= idx_prod[EXC_W +: KNEE_IDX_W];
			qe_s6 <= qe_s5;
			qr_s6 <= POS_W'(qe_s5) * POS_W'(KNEE_RANGE);
			idx_s7 <= idx_nxt;
			rem_s7 <= rem_nxt;
			a_s8 <= tab_a;
			d_s8 <= KNEE_D_W'(tab_b - tab_a);
			rem_s8 <= rem_s7;
			a_s9 <= a_s8;
			d_s9 <= d_s8;
			rem_hi_s9 <= rem_s8[EXC_W-1:REM_LO_W];
			plo_s9 <= PLO_W'(d_s8) * PLO_W'(rem_s8[REM_LO_W-1:0]);
			a_s10 <= a_s9;
			plo_s10 <= plo_s9;
			phi_s10 <= PHI_W'(d_s9) * PHI_W'(rem_hi_s9);
			a_s11 <= a_s10;
			p_s11 <= PROD2_W'(plo_s10) + (PROD2_W'(phi_s10) << REM_LO_W);
			a_s12 <= a_s11;
			p_s12 <= p_s11;
			qm_s12 <= QM_W'(p_s11[PROD2_W-1:FRAC_DROP]) * QM_W'(RECIP2);
			a_s13 <= a_s12;
			p_s13 <= p_s12;
			qe2_s13 <= qe2;
			qr2_s13 <= PROD2_W'(qe2) * PROD2_W'(KNEE_RANGE);
			a_s14 <= a_s13;
			g_s14 <= qe2_s13 + KNEE_D_W'(r2 >= PROD2_W'(KNEE_RANGE));
			lim_s15 <= lim_nxt;
		end
	end

	assign knee.mix = mix_s15;
	assign knee.lim = lim_s15;

endmodule

FILE: rtl/core/abmsl_meter.sv
// Output sign and rounding, peak meters and the limited-sample counter.
// Depends on abmsl_pkg.
module abmsl_meter import abmsl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input meter_ctl_t ctl,
	input knee_t knee,
	output result_t result
);

	logic [PEAK_W-1:0] tone_pk_q;
	logic [PEAK_W-1:0] drive_pk_q;
	logic [PEAK_W-1:0] cas_pk_q;
	logic [PREMIX_W-1:0] pre_pk_q;
	logic [PEAK_W-1:0] out_pk_q;
	logic [COUNT_W-1:0] count_q;

	logic [PEAK_W-1:0] base_tone;
	logic [PEAK_W-1:0] base_drive;
	logic [PEAK_W-1:0] base_cas;
	logic [PREMIX_W-1:0] base_pre;
	logic [PEAK_W-1:0] base_out;
	logic [COUNT_W-1:0] base_count;
	logic [MAG_W-FRAC_W-1:0] pre_raw;
	logic [PREMIX_W-1:0] pre_sat;
	logic [PEAK_W-1:0] out_mag;

	always_comb begin
		base_tone = knee.mix.clr ? '0 : tone_pk_q;
		base_drive = knee.mix.clr ? '0 : drive_pk_q;
		base_cas = knee.mix.clr ? '0 : cas_pk_q;
		base_pre = knee.mix.clr ? '0 : pre_pk_q;
		base_out = knee.mix.clr ? '0 : out_pk_q;
		base_count = knee.mix.clr ? '0 : count_q;

		pre_raw = knee.mix.mag[MAG_W-1:FRAC_W];
		pre_sat = pre_raw[MAG_W-FRAC_W-1] ? '1 : pre_raw[PREMIX_W-1:0];
		out_mag = PEAK_W'(knee.lim[LIM_W-1:FRAC_W]);

		result.mixed_out = '0;
		result.tone_peak = base_tone;
		result.drive_peak = base_drive;
		result.cassette_peak = base_cas;
		result.premix_peak = base_pre;
		result.output_peak = base_out;
		result.limited_count = base_count;

		// While muted the meters hold and only a clear reaches them.
		if (!ctl.mute) begin
			result.mixed_out = $signed(knee.mix.neg ? PEAK_W'(0) - out_mag : out_mag);
			result.tone_peak = (knee.mix.tone_pk > base_tone) ? knee.mix.tone_pk : base_tone;
			result.drive_peak = (knee.mix.drive_pk > base_drive) ?
				knee.mix.drive_pk : base_drive;
			result.cassette_peak = (knee.mix.cas_pk > base_cas) ? knee.mix.cas_pk : base_cas;
			result.premix_peak = (pre_sat > base_pre) ? pre_sat : base_pre;
			result.output_peak = (out_mag > base_out) ? out_mag : base_out;
			if (knee.mix.over && (base_count != '1)) begin
				result.limited_count = base_count + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_pk_q <= '0;
			drive_pk_q <= '0;
			cas_pk_q <= '0;
			pre_pk_q <= '0;
			out_pk_q <= '0;
			count_q <= '0;
		end else if (ctl.push) begin
			tone_pk_q <= result.tone_peak;
			drive_pk_q <= result.drive_peak;
			cas_pk_q <= result.cassette_peak;
			pre_pk_q <= result.premix_peak;
			out_pk_q <= result.output_peak;
			count_q <= result.limited_count;
		end
	end

endmodule

FILE: rtl/core/audio_bus_mixer_soft_limiter.sv
// Top level of the audio bus mixer with exponential soft limiter.
// Depends on abmsl_pkg, abmsl_mix, abmsl_knee and abmsl_meter.
//
//   Channel   Signals                                   Transfer when
//   sample    sample_valid, sample_stall, sample        valid high, stall low
//   result    result_valid, result_stall, result        valid high, stall low
//   config    psel, penable, pwrite, paddr, pwdata,     psel, penable, pwrite
//             prdata, pready                            and pready high
//
// The block takes one sample every cycle while sample_stall is low. result_valid
// rises once the sample has passed the fifteen pipeline stages (four in the mixer,
// eleven in the limiter, the first loaded by the transfer itself) and then the
// result register. A result that finds the result register full and not taken
// goes to the skid register; while the skid register is full the pipeline and
// the sample channel are held, and the next result transfer empties it. Reset
// clears the pipeline valid bits, the result and skid valid bits and the meters,
// and sets the configuration registers to their reset values.
module audio_bus_mixer_soft_limiter import abmsl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	input logic sample_valid,
	output logic sample_stall,
	input sample_t sample,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	// Configuration registers.
	logic mute_q;
	logic [GAIN_W-1:0] tone_gain_q;
	logic [GAIN_W-1:0] drive_gain_q;

	// Valid bit for each pipeline stage, and the two-entry output queue.
	logic [PIPE_STAGES-1:0] vld_q;
	logic res_vld_q;
	logic skid_vld_q;
	result_t res_q;
	result_t skid_q;

	logic cfg_wr;
	reg_idx_t reg_idx;
	logic en;
	logic push;
	logic pop;
	mix_t mix;
	knee_t knee;
	meter_ctl_t meter_ctl;
	result_t meter_res;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);

	// Registers sit at byte addresses 0, 4 and 8, decoded from paddr[3:2] only; index 3 writes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= 1'b0;
			tone_gain_q <= TONE_GAIN_RST;
			drive_gain_q <= DRIVE_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MUTE: begin
					mute_q <= pwdata[0];
				end
				REG_TONE_GAIN: begin
					tone_gain_q <= pwdata[GAIN_W-1:0];
				end
				REG_DRIVE_GAIN: begin
					drive_gain_q <= pwdata[GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MUTE: begin
				prdata = DATA_W'(mute_q);
			end
			REG_TONE_GAIN: begin
				prdata = DATA_W'(tone_gain_q);
			end
			REG_DRIVE_GAIN: begin
				prdata = DATA_W'(drive_gain_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// The whole pipeline moves together; it stops only once the skid register
	// holds a result, which keeps the input stall a registered signal.
	assign en = ~skid_vld_q;
	assign sample_stall = skid_vld_q;
	assign push = en & vld_q[PIPE_STAGES-1];
	assign pop = res_vld_q & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_STAGES-2:0], sample_valid};
		end
	end

	abmsl_mix u_mix (
		.clk(clk),
		.en(en),
		.sample(sample),
		.tone_gain(tone_gain_q),
		.drive_gain(drive_gain_q),
		.mix(mix)
	);

	abmsl_knee u_knee (
		.clk(clk),
		.en(en),
		.mix(mix),
		.knee(knee)
	);

	// The meters advance exactly when a finished sample enters the queue,
	// and each queued result keeps a snapshot of them.
	assign meter_ctl.push = push;
	assign meter_ctl.mute = mute_q;

	abmsl_meter u_meter (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(meter_ctl),
		.knee(knee),
		.result(meter_res)
	);

	// A push never meets a full skid register, since the pipeline is held then.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				res_vld_q <= push;
			end
		end else if (push) begin
			if (res_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				res_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			res_q <= skid_q;
		end else if (push && (pop || !res_vld_q)) begin
			res_q <= meter_res;
		end
		if (push && res_vld_q && !pop) begin
			skid_q <= meter_res;
		end
	end

	assign result_valid = res_vld_q;
	assign result = res_q;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for audio_bus_mixer_soft_limiter: a mixer/limiter/meter predictor,
// random sample and result flow control, and APB register writes. Depends on abmsl_pkg.
module tb_top;
	import abmsl_pkg::*;

	typedef longint unsigned u64_t;

	// Mix quantities are in Q.15 units: full scale, knee start, knee width and the
	// span of the knee table (eight knee widths).
	localparam u64_t FULL_SCALE = 64'd1073709056;
	localparam u64_t KNEE_BEGIN = 64'd1020023603;
	localparam u64_t KNEE_SPAN = 64'd53685453;
	localparam u64_t KNEE_REACH = 64'd429483624;
	localparam int KNEE_PTS = 256;
	localparam u64_t PREMIX_CAP = 64'd131071;
	localparam logic [15:0] TONE_GAIN_INIT = 16'd24576;
	localparam logic [15:0] DRIVE_GAIN_INIT = 16'd13107;

	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 185;
	localparam int TIMEOUT_NS = 3_000_000;

	// Tracks gains, mute and the meters, and works out the result of every sample
	// transfer. Results are matched in order against the queue of due results.
	class mix_meter_tracker;
		bit mute_on;
		bit [15:0] tone_gain_q;
		bit [15:0] drive_gain_q;
		bit [15:0] tone_pk;
		bit [15:0] drive_pk;
		bit [15:0] cas_pk;
		bit [16:0] premix_pk;
		bit [15:0] out_pk;
		bit [31:0] clip_count;
		u64_t knee_pts[KNEE_PTS+1];
		result_t due_results[$];
		int errors;

		// Builds the knee curve knee*(1-exp(-x/knee)) at KNEE_PTS+1 points. The step
		// ratio exp(-8/N) comes from a 20-term series in Q60, rounded to Q30.
		function new();
			u64_t term;
			u64_t series;
			u64_t ratio;
			u64_t pw;
			term = u64_t'(1) << 60;
			series = term;
			for (int k = 1; k <= 20; k++) begin
				term = term * 8 / (u64_t'(KNEE_PTS) * u64_t'(k));
				if (k % 2 == 1) begin
					series -= term;
				end else begin
					series += term;
				end
			end
			ratio = (series + (u64_t'(1) << 29)) >> 30;
			pw = u64_t'(1) << 30;
			for (int i = 0; i <= KNEE_PTS; i++) begin
				knee_pts[i] = KNEE_SPAN - ((KNEE_SPAN * pw + (u64_t'(1) << 29)) >> 30);
				pw = (pw * ratio + (u64_t'(1) << 29)) >> 30;
			end
			mute_on = 1'b0;
			tone_gain_q = TONE_GAIN_INIT;
			drive_gain_q = DRIVE_GAIN_INIT;
			clear_meters();
			errors = 0;
		endfunction

		function void clear_meters();
			tone_pk = '0;
			drive_pk = '0;
			cas_pk = '0;
			premix_pk = '0;
			out_pk = '0;
			clip_count = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
			REG_MUTE: mute_on = value[0];
			REG_TONE_GAIN: tone_gain_q = value[15:0];
			REG_DRIVE_GAIN: drive_gain_q = value[15:0];
			default: ;
			endcase
		endfunction

		function u64_t magnitude(longint v);
			return (v < 0) ? u64_t'(-v) : u64_t'(v);
		endfunction

		function u64_t larger(u64_t a, u64_t b);
			return (a > b) ? a : b;
		endfunction

		// Soft-limit gain for an excess e above the knee start, interpolated linearly
		// between table points and held at one knee width from the end of the table on.
		function u64_t knee_gain(u64_t e);
			u64_t pos;
			u64_t idx;
			u64_t rem;
			u64_t a;
			u64_t b;
			if (e >= KNEE_REACH) begin
				return KNEE_SPAN;
			end
			pos = e * u64_t'(KNEE_PTS);
			idx = pos / KNEE_REACH;
			rem = pos % KNEE_REACH;
			if (idx >= u64_t'(KNEE_PTS)) begin
				return KNEE_SPAN;
			end
			a = knee_pts[idx];
			b = knee_pts[idx + 1];
			return a + (b - a) * rem / KNEE_REACH;
		endfunction

		function void take_sample(sample_t s);
			longint tone_q;
			longint drive_q;
			longint cas_q;
			longint mix;
			longint outv;
			u64_t mag;
			u64_t lim;
			u64_t pre;
			result_t r;
			tone_q = longint'($signed(s.tone_sample)) * longint'(tone_gain_q);
			drive_q = s.drive_present ?
				longint'($signed(s.drive_sample)) * longint'(drive_gain_q) : 0;
			cas_q = s.cassette_present ? longint'($signed(s.cassette_sample)) * 32768 : 0;
			if (s.clear_meters) begin
				clear_meters();
			end
			r = '0;
			if (!mute_on) begin
				mix = tone_q + drive_q + cas_q;
				mag = magnitude(mix);
				if (mag > KNEE_BEGIN) begin
					lim = KNEE_BEGIN + knee_gain(mag - KNEE_BEGIN);
					if (clip_count != 32'hFFFF_FFFF) begin
						clip_count++;
					end
				end else begin
					lim = mag;
				end
				if (lim > FULL_SCALE) begin
					lim = FULL_SCALE;
				end
				outv = longint'(lim >> 15);
				if (mix < 0) begin
					outv = -outv;
				end
				r.mixed_out = outv[15:0];
				tone_pk = 16'(larger(tone_pk, magnitude(tone_q) >> 15));
				drive_pk = 16'(larger(drive_pk, magnitude(drive_q) >> 15));
				cas_pk = 16'(larger(cas_pk, magnitude(cas_q) >> 15));
				pre = mag >> 15;
				if (pre > PREMIX_CAP) begin
					pre = PREMIX_CAP;
				end
				premix_pk = 17'(larger(premix_pk, pre));
				out_pk = 16'(larger(out_pk, lim >> 15));
			end
			r.tone_peak = tone_pk;
			r.drive_peak = drive_pk;
			r.cassette_peak = cas_pk;
			r.premix_peak = premix_pk;
			r.output_peak = out_pk;
			r.limited_count = clip_count;
			due_results.push_back(r);
		endfunction

		function void check_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result transfer with no sample outstanding (mixed_out %0d)",
					$signed(got.mixed_out));
				errors++;
				return;
			end
			want = due_results.pop_front();
			check_field("mixed_out", $signed(want.mixed_out), $signed(got.mixed_out));
			check_field("tone_peak", want.tone_peak, got.tone_peak);
			check_field("drive_peak", want.drive_peak, got.drive_peak);
			check_field("cassette_peak", want.cassette_peak, got.cassette_peak);
			check_field("premix_peak", want.premix_peak, got.premix_peak);
			check_field("output_peak", want.output_peak, got.output_peak);
			check_field("limited_count", want.limited_count, got.limited_count);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;

	mix_meter_tracker tracker = new();

	// Sender burst bookkeeping: the number of transfers left in the current burst,
	// and a switch that suppresses gaps entirely.
	int burst_left = 0;
	bit steady_send = 1'b0;
	// Raised by the stimulus to ask the receiver for one long hold-off.
	bit hold_off_req = 1'b0;

	always #4 clk = ~clk;

	audio_bus_mixer_soft_limiter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Every result transfer is checked against the oldest due result. Sampling at
	// the rising edge sees the values that the block presented during the cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			tracker.match_result(result);
		end
	end

	// Receiver flow control. Modes change after random stretches: no stall at all,
	// light random stall, heavy random stall, and an alternating stall. On request
	// the receiver holds off so that the pipeline and its skid register fill and the
	// block has to stall the sample channel.
	initial begin : result_stall_pattern
		int mode;
		int left;
		int held;
		mode = 0;
		left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				for (held = 0; held < LONG_HOLD; held++) begin
					@(negedge clk);
				end
				hold_off_req = 1'b0;
				result_stall <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(8, 150);
				end
				left--;
				case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= ~result_stall;
				endcase
			end
		end
	end

	initial begin : run_limit
		#(TIMEOUT_NS);
		$display("tb_top: errors");
		$finish;
	end

	function automatic sample_t make_sample(int tone, int drive, bit drive_on, int cas,
			bit cas_on, bit clr);
		sample_t s;
		s.tone_sample = 16'(tone);
		s.drive_sample = 16'(drive);
		s.drive_present = drive_on;
		s.cassette_sample = 16'(cas);
		s.cassette_present = cas_on;
		s.clear_meters = clr;
		return s;
	endfunction

	// Sample levels weighted toward the rails, small values and the region around
	// the knee, so the limiter sees every branch often.
	function automatic int rand_level();
		int v;
		case ($urandom_range(0, 7))
		0: v = -32768;
		1: v = 32767;
		2: v = $urandom_range(0, 128) - 64;
		3: begin
			v = $urandom_range(30000, 32767);
			if ($urandom_range(0, 1) == 1) begin
				v = -v;
			end
		end
		default: v = $urandom_range(0, 65535);
		endcase
		return v;
	endfunction

	function automatic sample_t rand_sample();
		return make_sample(rand_level(), rand_level(), $urandom_range(0, 3) != 0,
			rand_level(), $urandom_range(0, 3) != 0, $urandom_range(0, 39) == 0);
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 4))
		0: return 32'd0;
		1: return 32'd32768;
		2: return 32'd65535;
		default: return 32'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offers one sample and returns once it has been taken. Between bursts the sender may
	// drop valid for a random gap unless steady_send is set; within a burst valid stays high.
	task automatic offer_sample(input sample_t s);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = (steady_send || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		sample_valid <= 1'b1;
		sample <= s;
		do begin
			@(posedge clk);
		end while (sample_stall);
		tracker.take_sample(s);
	endtask

	// Stops sending and waits until every due result has been transferred.
	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		burst_left = 0;
		while (tracker.due_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One APB write followed by a read of the same register, which must return
	// the written value within the register's width.
	task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] readback;
		mask = (idx == REG_MUTE) ? 32'h1 : 32'hFFFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		tracker.set_reg(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		readback = prdata;
		if (readback !== (value & mask)) begin
			$error("prdata of %s: expected %0d, got %0d", idx.name(), value & mask, readback);
			tracker.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		int items;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		sample = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset gains: absent sources, rails, both sides of the knee start, deep
		// limiting past the end of the table, and clears with and without a sample.
		reg_write(REG_MUTE, 32'd0);
		reg_write(REG_TONE_GAIN, 32'd24576);
		reg_write(REG_DRIVE_GAIN, 32'd13107);
		offer_sample(make_sample(0, 0, 1'b0, 0, 1'b0, 1'b1));
		offer_sample(make_sample(32767, 32767, 1'b0, -32768, 1'b0, 1'b0));
		offer_sample(make_sample(-32768, 0, 1'b0, 0, 1'b0, 1'b0));
		offer_sample(make_sample(0, -32768, 1'b1, 0, 1'b0, 1'b0));
		offer_sample(make_sample(0, 0, 1'b0, 31128, 1'b1, 1'b0));
		offer_sample(make_sample(0, 0, 1'b0, 31129, 1'b1, 1'b0));
		offer_sample(make_sample(0, 0, 1'b0, -32768, 1'b1, 1'b0));
		offer_sample(make_sample(-32768, -32768, 1'b1, -32768, 1'b1, 1'b0));
		offer_sample(make_sample(32767, 32767, 1'b1, 32767, 1'b1, 1'b0));
		offer_sample(make_sample(16'hAAAA, 16'h5555, 1'b1, 16'h5555, 1'b1, 1'b0));
		offer_sample(make_sample(12345, -23456, 1'b1, 4000, 1'b0, 1'b1));

		// Gains just under two: the pre-limiter peak has to saturate.
		drain_results();
		reg_write(REG_TONE_GAIN, 32'd65535);
		reg_write(REG_DRIVE_GAIN, 32'd65535);
		offer_sample(make_sample(-32768, -32768, 1'b1, -32768, 1'b1, 1'b0));
		offer_sample(make_sample(32767, 32767, 1'b1, 32767, 1'b1, 1'b0));
		offer_sample(make_sample(-32768, 0, 1'b0, 0, 1'b0, 1'b1));

		// Zero gains leave only the cassette path.
		drain_results();
		reg_write(REG_TONE_GAIN, 32'd0);
		reg_write(REG_DRIVE_GAIN, 32'd0);
		offer_sample(make_sample(32767, -32768, 1'b1, 100, 1'b1, 1'b0));
		offer_sample(make_sample(-1, -1, 1'b1, -1, 1'b1, 1'b0));

		// Muted: output zero, meters frozen, though a clear still takes effect.
		drain_results();
		reg_write(REG_MUTE, 32'd1);
		offer_sample(make_sample(32767, 32767, 1'b1, 32767, 1'b1, 1'b0));
		offer_sample(make_sample(1000, 0, 1'b0, 0, 1'b0, 1'b1));
		offer_sample(make_sample(-32768, -32768, 1'b1, -32768, 1'b1, 1'b0));

		// Unity gains after unmuting.
		drain_results();
		reg_write(REG_MUTE, 32'd0);
		reg_write(REG_TONE_GAIN, 32'd32768);
		reg_write(REG_DRIVE_GAIN, 32'd32768);
		offer_sample(make_sample(32767, 0, 1'b0, 0, 1'b0, 1'b0));
		offer_sample(make_sample(-32768, -32768, 1'b1, 0, 1'b0, 1'b0));
		offer_sample(make_sample(1, -1, 1'b1, -1, 1'b1, 1'b0));

		// Random phases, each with its own gains. One phase runs muted; in another
		// the sender never pauses while the receiver holds off for a long time.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			reg_write(REG_MUTE, (ph == 3) ? 32'd1 : 32'd0);
			reg_write(REG_TONE_GAIN, pick_gain());
			reg_write(REG_DRIVE_GAIN, pick_gain());
			steady_send = (ph == 2);
			if (ph == 2) begin
				hold_off_req = 1'b1;
			end
			items = (ph == 3) ? 60 : PHASE_ITEMS;
			for (int n = 0; n < items; n++) begin
				offer_sample(rand_sample());
			end
		end
		steady_send = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.due_results.size() != 0) begin
			$error("%0d results never arrived", tracker.due_results.size());
			tracker.errors++;
		end
		if (tracker.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
